[hw/rtl/ppcid_pkg.sv]
// ----------------------------------------------------------------------------
// ppcid_pkg
// Shared types and decode functions for the instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppcid_pkg;

    localparam int unsigned OpW = 8;

    // Registered input word plus its valid flag
    typedef struct packed {
        logic        valid;
        logic [31:0] word;
    } t_in_stage;

    // Decode result handed to the output stage
    typedef struct packed {
        logic [OpW-1:0] op_num;
        logic           unknown;
        logic           sub;
    } t_dec_result;

    // Primary opcode; 255 marks a secondary-decode opcode
    localparam logic [OpW-1:0] PrimSub = 8'd255;

    function automatic logic [OpW-1:0] prim_lookup(input logic [5:0] p);
        logic [OpW-1:0] r;
        unique case (p)
            6'd3: r = 8'd3;   6'd7: r = 8'd5;   6'd8: r = 8'd6;
            6'd10: r = 8'd7;  6'd11: r = 8'd8;  6'd12: r = 8'd9;
            6'd13: r = 8'd10; 6'd14: r = 8'd11; 6'd15: r = 8'd12;
            6'd16: r = 8'd1;  6'd17: r = 8'd4;  6'd18: r = 8'd2;
            6'd20: r = 8'd13; 6'd21: r = 8'd14; 6'd23: r = 8'd15;
            6'd24: r = 8'd16; 6'd25: r = 8'd17; 6'd26: r = 8'd18;
            6'd27: r = 8'd19; 6'd28: r = 8'd20; 6'd29: r = 8'd21;
            6'd32: r = 8'd22; 6'd33: r = 8'd23; 6'd34: r = 8'd24;
            6'd35: r = 8'd25; 6'd36: r = 8'd32; 6'd37: r = 8'd33;
            6'd38: r = 8'd34; 6'd39: r = 8'd35; 6'd40: r = 8'd26;
            6'd41: r = 8'd27; 6'd42: r = 8'd28; 6'd43: r = 8'd29;
            6'd44: r = 8'd30; 6'd45: r = 8'd31; 6'd46: r = 8'd36;
            6'd47: r = 8'd37; 6'd48: r = 8'd38; 6'd49: r = 8'd39;
            6'd50: r = 8'd40; 6'd51: r = 8'd41; 6'd52: r = 8'd42;
            6'd53: r = 8'd43; 6'd54: r = 8'd44; 6'd55: r = 8'd45;
            6'd56: r = 8'd46; 6'd57: r = 8'd47; 6'd60: r = 8'd48;
            6'd61: r = 8'd49;
            6'd4, 6'd19, 6'd31, 6'd59, 6'd63: r = PrimSub;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Opcode 4: exact field, then low 6 bits, then low 5 bits
    function automatic logic [OpW-1:0] op4_lookup(input logic [9:0] x);
        logic [OpW-1:0] r;
        unique case (x)
            10'd0: r = 8'd50;   10'd32: r = 8'd51;  10'd40: r = 8'd52;
            10'd136: r = 8'd53; 10'd264: r = 8'd54; 10'd64: r = 8'd55;
            10'd72: r = 8'd56;  10'd96: r = 8'd57;  10'd528: r = 8'd58;
            10'd560: r = 8'd59; 10'd592: r = 8'd60; 10'd624: r = 8'd61;
            10'd1014: r = 8'd62;
            default: r = 8'd0;
        endcase
        if (r == 8'd0) begin
            case (x[5:0])
                6'd6: r = 8'd80;  6'd7: r = 8'd81;
                6'd38: r = 8'd82; 6'd39: r = 8'd83;
                default: r = 8'd0;
            endcase
        end
        if (r == 8'd0) begin
            case (x[4:0])
                5'd10: r = 8'd63; 5'd11: r = 8'd64; 5'd12: r = 8'd65;
                5'd13: r = 8'd66; 5'd14: r = 8'd67; 5'd15: r = 8'd68;
                5'd18: r = 8'd69; 5'd20: r = 8'd70; 5'd21: r = 8'd71;
                5'd23: r = 8'd72; 5'd24: r = 8'd73; 5'd25: r = 8'd74;
                5'd26: r = 8'd75; 5'd28: r = 8'd76; 5'd29: r = 8'd77;
                5'd30: r = 8'd78; 5'd31: r = 8'd79;
                default: r = 8'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [OpW-1:0] op19_lookup(input logic [9:0] x);
        logic [OpW-1:0] r;
        unique case (x)
            10'd528: r = 8'd84; 10'd16: r = 8'd85;  10'd257: r = 8'd86;
            10'd129: r = 8'd87; 10'd289: r = 8'd88; 10'd225: r = 8'd89;
            10'd33: r = 8'd90;  10'd449: r = 8'd91; 10'd417: r = 8'd92;
            10'd193: r = 8'd93; 10'd150: r = 8'd94; 10'd0: r = 8'd95;
            10'd50: r = 8'd96;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [OpW-1:0] op31_lookup(input logic [9:0] x);
        logic [OpW-1:0] r;
        unique case (x)
            10'd266, 10'd778: r = 8'd97;
            10'd10, 10'd522: r = 8'd98;
            10'd138, 10'd650: r = 8'd99;
            10'd234, 10'd746: r = 8'd100;
            10'd202, 10'd714: r = 8'd101;
            10'd491, 10'd1003: r = 8'd102;
            10'd459, 10'd971: r = 8'd103;
            10'd75: r = 8'd104;
            10'd11: r = 8'd105;
            10'd235, 10'd747: r = 8'd106;
            10'd104, 10'd616: r = 8'd107;
            10'd40, 10'd552: r = 8'd108;
            10'd8, 10'd520: r = 8'd109;
            10'd136, 10'd648: r = 8'd110;
            10'd232, 10'd744: r = 8'd111;
            10'd200, 10'd712: r = 8'd112;
            10'd28: r = 8'd113;  10'd60: r = 8'd114;  10'd444: r = 8'd115;
            10'd124: r = 8'd116; 10'd316: r = 8'd117; 10'd412: r = 8'd118;
            10'd476: r = 8'd119; 10'd284: r = 8'd120; 10'd0: r = 8'd121;
            10'd32: r = 8'd122;  10'd26: r = 8'd123;  10'd922: r = 8'd124;
            10'd954: r = 8'd125; 10'd536: r = 8'd126; 10'd792: r = 8'd127;
            10'd824: r = 8'd128; 10'd24: r = 8'd129;  10'd54: r = 8'd130;
            10'd86: r = 8'd131;  10'd246: r = 8'd132; 10'd278: r = 8'd133;
            10'd470: r = 8'd134; 10'd758: r = 8'd135; 10'd1014: r = 8'd136;
            10'd23: r = 8'd137;  10'd55: r = 8'd138;  10'd279: r = 8'd139;
            10'd311: r = 8'd140; 10'd343: r = 8'd141; 10'd375: r = 8'd142;
            10'd87: r = 8'd143;  10'd119: r = 8'd144; 10'd534: r = 8'd145;
            10'd790: r = 8'd146; 10'd150: r = 8'd147; 10'd20: r = 8'd148;
            10'd533: r = 8'd149; 10'd597: r = 8'd150; 10'd151: r = 8'd151;
            10'd183: r = 8'd152; 10'd407: r = 8'd153; 10'd439: r = 8'd154;
            10'd215: r = 8'd155; 10'd247: r = 8'd156; 10'd662: r = 8'd157;
            10'd918: r = 8'd158; 10'd661: r = 8'd159; 10'd725: r = 8'd160;
            10'd535: r = 8'd161; 10'd567: r = 8'd162; 10'd599: r = 8'd163;
            10'd631: r = 8'd164; 10'd663: r = 8'd165; 10'd695: r = 8'd166;
            10'd727: r = 8'd167; 10'd759: r = 8'd168; 10'd983: r = 8'd169;
            10'd19: r = 8'd170;  10'd83: r = 8'd171;  10'd144: r = 8'd172;
            10'd146: r = 8'd173; 10'd210: r = 8'd174; 10'd242: r = 8'd175;
            10'd339: r = 8'd176; 10'd467: r = 8'd177; 10'd371: r = 8'd178;
            10'd512: r = 8'd179; 10'd595: r = 8'd180; 10'd659: r = 8'd181;
            10'd4: r = 8'd182;   10'd598: r = 8'd183; 10'd982: r = 8'd184;
            10'd310: r = 8'd185; 10'd438: r = 8'd186; 10'd854: r = 8'd187;
            10'd306: r = 8'd188; 10'd566: r = 8'd189;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [OpW-1:0] op59_lookup(input logic [4:0] x);
        logic [OpW-1:0] r;
        case (x)
            5'd18: r = 8'd190; 5'd20: r = 8'd191; 5'd21: r = 8'd192;
            5'd24: r = 8'd193; 5'd25: r = 8'd194; 5'd28: r = 8'd195;
            5'd29: r = 8'd196; 5'd30: r = 8'd197; 5'd31: r = 8'd198;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Opcode 63: exact field, then low 5 bits
    function automatic logic [OpW-1:0] op63_lookup(input logic [9:0] x);
        logic [OpW-1:0] r;
        unique case (x)
            10'd264: r = 8'd199; 10'd32: r = 8'd200;  10'd0: r = 8'd201;
            10'd14: r = 8'd202;  10'd15: r = 8'd203;  10'd72: r = 8'd204;
            10'd136: r = 8'd205; 10'd40: r = 8'd206;  10'd12: r = 8'd207;
            10'd64: r = 8'd208;  10'd583: r = 8'd209; 10'd70: r = 8'd210;
            10'd38: r = 8'd211;  10'd134: r = 8'd212; 10'd711: r = 8'd213;
            default: r = 8'd0;
        endcase
        if (r == 8'd0) begin
            case (x[4:0])
                5'd18: r = 8'd214; 5'd20: r = 8'd215; 5'd21: r = 8'd216;
                5'd23: r = 8'd217; 5'd25: r = 8'd218; 5'd26: r = 8'd219;
                5'd28: r = 8'd220; 5'd29: r = 8'd221; 5'd30: r = 8'd222;
                5'd31: r = 8'd223;
                default: r = 8'd0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ppc_instruction_decoder_top.sv]
// ----------------------------------------------------------------------------
// ppc_instruction_decoder_top
// Decodes a 32-bit instruction word into an operation number.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* takes one instruction word per transfer in
//   s_axis_tdata. Master channel m_axis_* returns one result word per
//   instruction: operation number, unknown flag and subtable flag.
//   The word is captured in an input register, decoded by table logic, and
//   written to the output register.
//   Throughput is one word per cycle unless stalled; the output register
//   reloads in the cycle it is drained, so both registers advance together.
//   When the receiver stalls, the output register holds its word and the
//   input register holds the next one; tready drops only when both are full.
//   Synchronous active-low reset empties both registers; no words are
//   presented after reset until new input arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_instruction_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] instruction_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [7:0] operation_number,
                                             // [8] is_unknown, [9] used_subtable
);

    ppcid_pkg::t_in_stage   r_in;
    ppcid_pkg::t_dec_result dec;
    ppcid_pkg::t_dec_result r_out;
    logic                   r_out_vld;
    logic                   out_free;
    logic                   adv;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign adv           = r_in.valid && out_free;
    assign s_axis_tready = !r_in.valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in.valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.word <= s_axis_tdata;
        end
    end

    ppcid_decode u_decode (
        .i_word (r_in.word),
        .o_res  (dec)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in.valid;
        end
        if (adv) begin
            r_out <= dec;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.sub, r_out.unknown, r_out.op_num};

endmodule

`default_nettype wire

[hw/rtl/ppcid_decode.sv]
// ----------------------------------------------------------------------------
// ppcid_decode
// Combinational primary and secondary opcode decode of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcid_decode (
    input  wire logic [31:0]          i_word,
    output ppcid_pkg::t_dec_result    o_res
);

    logic [5:0]                  prim;
    logic [9:0]                  ext10;
    logic [ppcid_pkg::OpW-1:0]   p_num;
    logic [ppcid_pkg::OpW-1:0]   num;

    assign prim  = i_word[31:26];
    assign ext10 = i_word[10:1];
    assign p_num = ppcid_pkg::prim_lookup(prim);

    // Secondary table selection
    always_comb begin
        num = p_num;
        if (p_num == ppcid_pkg::PrimSub) begin
            unique case (prim)
                6'd4:    num = ppcid_pkg::op4_lookup(ext10);
                6'd19:   num = ppcid_pkg::op19_lookup(ext10);
                6'd31:   num = ppcid_pkg::op31_lookup(ext10);
                6'd59:   num = ppcid_pkg::op59_lookup(ext10[4:0]);
                default: num = ppcid_pkg::op63_lookup(ext10);
            endcase
        end
    end

    assign o_res.op_num  = num;
    assign o_res.unknown = (num == '0);
    assign o_res.sub     = (p_num == ppcid_pkg::PrimSub);

endmodule

`default_nettype wire
